FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every clock edge outside reset.
`define WCP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define WCP_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define WCP_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/wcp_pkg.sv
package wcp_pkg;

	// Display and window limits
	localparam int unsigned MAX_WIDTH       = 1440;
	localparam int unsigned MAX_HEIGHT      = 512;
	localparam int unsigned MAX_WINDOW      = 191399;
	localparam int unsigned LINE_MODE_LIMIT = 4096;
	localparam int unsigned MIN_DIM         = 32;

	// Register reset values
	localparam int unsigned WINDOW_RESET = 44100;
	localparam int unsigned GAIN_RESET   = 256;
	localparam int unsigned WIDTH_RESET  = 512;
	localparam int unsigned HEIGHT_RESET = 150;

	// Field and datapath widths
	localparam int SAMPLE_W   = 16;
	localparam int ACC_W      = 34;
	localparam int CNT_W      = 18;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 9;
	localparam int GAIN_W     = 10;
	localparam int HGT_W      = 10;
	localparam int M1_W       = 9;
	localparam int PROD_W     = ACC_W + M1_W + GAIN_W;
	localparam int QUOT_W     = 12;
	localparam int FRAC_SHIFT = 23;
	localparam int STEP_W     = 4;
	localparam int CFG_W      = 18;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW = 2'd0,
		REG_GAIN   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} wcp_reg_t;

	// One column job for the multiply-divide unit
	typedef struct packed {
		logic [ACC_W-1:0]  mag;
		logic [M1_W-1:0]   m1;
		logic [CNT_W-1:0]  count;
		logic [GAIN_W-1:0] gain;
	} wcp_job_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} wcp_res_t;

endpackage

FILE: rtl/wcp_in_if.sv
interface wcp_in_if import wcp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       window_start;

	modport source(output valid, output sample, output window_start, input ready);
	modport sink(input valid, input sample, input window_start, output ready);
endinterface

FILE: rtl/wcp_out_if.sv
interface wcp_out_if import wcp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row_top;
	logic [ROW_W-1:0] row_bottom;

	modport source(output valid, output column, output row_top, output row_bottom, input ready);
	modport sink(input valid, input column, input row_top, input row_bottom, output ready);
endinterface

FILE: rtl/wcp_mdu.sv
`include "assert_macros.svh"

// Iterative unit: |sum| * m1 * gain by shift-add, then >> 23 and a restoring
// divide by the sample count. One adder serves every step.
module wcp_mdu import wcp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  wcp_job_t job,
	input  logic     ack,
	output wcp_res_t res
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL1 = 5'b00010,
		S_MUL2 = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} mdu_state_t;

	mdu_state_t        state_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] opnd_q;
	logic [GAIN_W-1:0] mplier_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic [GAIN_W-1:0] gain_q;
	logic [CNT_W-1:0]  count_q;

	logic [PROD_W-1:0] add_b;
	logic              add_cin;
	logic [PROD_W:0]   add_full;
	logic              carry;
	logic [PROD_W-1:0] acc_mul;

	always_comb begin
		add_cin  = (state_q == S_DIV);
		add_b    = add_cin ? ~opnd_q : opnd_q;
		add_full = {1'b0, acc_q} + {1'b0, add_b} + (PROD_W+1)'(add_cin);
		carry    = add_full[PROD_W];
		acc_mul  = mplier_q[0] ? add_full[PROD_W-1:0] : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_MUL1;
				S_MUL1: if (step_q == '0) state_q <= S_MUL2;
				S_MUL2: if (step_q == '0) state_q <= S_DIV;
				S_DIV:  if (step_q == '0) state_q <= S_DONE;
				S_DONE: if (ack) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					acc_q    <= '0;
					opnd_q   <= PROD_W'(job.mag);
					mplier_q <= GAIN_W'(job.m1);
					step_q   <= STEP_W'(M1_W - 1);
					gain_q   <= job.gain;
					count_q  <= job.count;
				end
			end
			S_MUL1: begin
				if (step_q == '0) begin
					opnd_q   <= acc_mul;
					acc_q    <= '0;
					mplier_q <= gain_q;
					step_q   <= STEP_W'(GAIN_W - 1);
				end else begin
					acc_q    <= acc_mul;
					opnd_q   <= opnd_q << 1;
					mplier_q <= mplier_q >> 1;
					step_q   <= step_q - 1'b1;
				end
			end
			S_MUL2: begin
				if (step_q == '0) begin
					acc_q  <= acc_mul >> FRAC_SHIFT;
					opnd_q <= PROD_W'(count_q) << (QUOT_W - 1);
					quot_q <= '0;
					step_q <= STEP_W'(QUOT_W - 1);
				end else begin
					acc_q    <= acc_mul;
					opnd_q   <= opnd_q << 1;
					mplier_q <= mplier_q >> 1;
					step_q   <= step_q - 1'b1;
				end
			end
			S_DIV: begin
				// keep the difference only when it did not borrow
				if (carry) acc_q <= add_full[PROD_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], carry};
				opnd_q <= opnd_q >> 1;
				if (step_q != '0) step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign res.done = (state_q == S_DONE);
	assign res.quot = quot_q;

	`WCP_ASSERT(a_start_idle, clk, arst_n, start |-> state_q == S_IDLE, "job started while busy")
	`WCP_ASSERT(a_hold_result, clk, arst_n, res.done && !ack |=> res.done && $stable(res.quot), "result dropped")
	`WCP_ASSERT(a_div_bound, clk, arst_n, state_q == S_DIV |-> acc_q < (opnd_q << 1), "quotient overflow")

endmodule

FILE: rtl/waveform_column_plotter.sv
// A sample that closes a column inside the display width starts a job in the shared unit
// (9 + 10 multiply steps, 12 divide steps); its span shows on spans once the unit hands the
// result to the output register. A column closed past the display width emits nothing.
// Throughput: one sample per cycle while no column is in the unit; samples is held off from
// each emitted column until its result is handed over, longer while a finished span waits on
// spans. Reset (arst_n low) clears all accumulators and control state and loads the register reset values.
`include "assert_macros.svh"

module waveform_column_plotter import wcp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	wcp_in_if.sink               samples,
	wcp_out_if.source            spans
);

	// Configuration registers
	logic [CNT_W-1:0]  window_q;
	logic [GAIN_W-1:0] gain_q;
	logic [COL_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;

	// Window accumulators
	logic signed [ACC_W-1:0] sum_q;
	logic [ACC_W-1:0]        abs_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        pos_q;
	logic [COL_W-1:0]        col_q;

	// Job in flight
	logic             busy_q;
	logic [COL_W-1:0] col_job_q;
	logic [HGT_W-1:0] hgt_job_q;
	logic             line_job_q;
	logic             neg_job_q;

	// Output register
	logic             out_valid_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_top_q;
	logic [ROW_W-1:0] out_bot_q;

	// Clamped settings
	logic [COL_W-1:0] w_cl;
	logic [HGT_W-1:0] h_cl;
	logic [CNT_W-1:0] z_cl;
	logic             line_mode;
	logic [M1_W-1:0]  mid_cl;

	// Accept-cycle datapath
	logic                    take;
	logic signed [ACC_W-1:0] s_ext;
	logic [ACC_W-1:0]        s_abs;
	logic signed [ACC_W-1:0] base_sum;
	logic [ACC_W-1:0]        base_abs;
	logic [CNT_W-1:0]        base_cnt;
	logic [CNT_W-1:0]        base_pos;
	logic [COL_W-1:0]        base_col;
	logic signed [ACC_W-1:0] sum_nxt;
	logic [ACC_W-1:0]        abs_nxt;
	logic [CNT_W-1:0]        cnt_nxt;
	logic                    closing;
	logic                    emit;
	logic [CNT_W-1:0]        pos_sub;
	logic [CNT_W:0]          pos_add;
	logic [CNT_W-1:0]        pos_nxt;
	logic                    sum_neg;

	// Unit handshake
	wcp_job_t job;
	wcp_res_t res;
	logic     load;

	// Span mapping
	logic [M1_W-1:0]         mid_job;
	logic [M1_W-1:0]         m1_job;
	logic [HGT_W-1:0]        hi_job;
	logic signed [13:0]      defl;
	logic signed [13:0]      row_dot;
	logic [ROW_W-1:0]        dot_row;
	logic [M1_W-1:0]         amp;
	logic [ROW_W-1:0]        line_top;
	logic [HGT_W-1:0]        line_bot;

	always_comb begin
		w_cl = width_q;
		if (width_q < COL_W'(MIN_DIM)) w_cl = COL_W'(MIN_DIM);
		else if (width_q > COL_W'(MAX_WIDTH)) w_cl = COL_W'(MAX_WIDTH);

		h_cl = height_q;
		if (height_q < HGT_W'(MIN_DIM)) h_cl = HGT_W'(MIN_DIM);
		else if (height_q > HGT_W'(MAX_HEIGHT)) h_cl = HGT_W'(MAX_HEIGHT);

		z_cl = window_q;
		if (window_q < CNT_W'(MIN_DIM)) z_cl = CNT_W'(MIN_DIM);
		else if (window_q > CNT_W'(MAX_WINDOW)) z_cl = CNT_W'(MAX_WINDOW);

		line_mode = (z_cl > CNT_W'(LINE_MODE_LIMIT));
		mid_cl    = h_cl[HGT_W-1:1];
	end

	// Fold the sample in; a window start clears everything first.
	always_comb begin
		take     = samples.valid && samples.ready;
		s_ext    = ACC_W'(samples.sample);
		s_abs    = samples.sample[SAMPLE_W-1] ? ACC_W'(-s_ext) : ACC_W'(s_ext);
		base_sum = samples.window_start ? '0 : sum_q;
		base_abs = samples.window_start ? '0 : abs_q;
		base_cnt = samples.window_start ? '0 : cnt_q;
		base_pos = samples.window_start ? '0 : pos_q;
		base_col = samples.window_start ? '0 : col_q;

		sum_nxt = base_sum + s_ext;
		abs_nxt = base_abs + s_abs;
		cnt_nxt = (base_cnt == '1) ? base_cnt : base_cnt + 1'b1;

		// position is tested before it advances
		closing = (base_pos > z_cl);
		emit    = closing && (base_col < w_cl);
		pos_sub = closing ? base_pos - z_cl : base_pos;
		pos_add = {1'b0, pos_sub} + (CNT_W+1)'(w_cl);
		pos_nxt = pos_add[CNT_W] ? '1 : pos_add[CNT_W-1:0];
		sum_neg = sum_nxt[ACC_W-1];

		job.mag   = line_mode ? abs_nxt : (sum_neg ? ACC_W'(-sum_nxt) : ACC_W'(sum_nxt));
		job.m1    = mid_cl - 1'b1;
		job.count = cnt_nxt;
		job.gain  = gain_q;
	end

	wcp_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take && emit),
		.job    (job),
		.ack    (load),
		.res    (res)
	);

	// Map the quotient to rows about mid-height.
	always_comb begin
		mid_job = hgt_job_q[HGT_W-1:1];
		m1_job  = mid_job - 1'b1;
		hi_job  = hgt_job_q - 1'b1;

		defl    = neg_job_q ? -$signed(14'(res.quot)) : $signed(14'(res.quot));
		row_dot = $signed(14'(mid_job)) - defl;
		if (row_dot < 14'sd1) dot_row = ROW_W'(1);
		else if (row_dot > $signed(14'(hi_job))) dot_row = ROW_W'(hi_job);
		else dot_row = ROW_W'(row_dot);

		amp      = (res.quot > QUOT_W'(m1_job)) ? m1_job : M1_W'(res.quot);
		line_top = ROW_W'(mid_job - amp);
		line_bot = HGT_W'(mid_job) + HGT_W'(amp);

		// hand the result over once the output register is free
		load = res.done && (!out_valid_q || spans.ready);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= CNT_W'(WINDOW_RESET);
			gain_q   <= GAIN_W'(GAIN_RESET);
			width_q  <= COL_W'(WIDTH_RESET);
			height_q <= HGT_W'(HEIGHT_RESET);
		end else if (cfg_we) begin
			case (wcp_reg_t'(cfg_index))
				REG_WINDOW: window_q <= cfg_data[CNT_W-1:0];
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[COL_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Accumulators and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			abs_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			col_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				pos_q <= pos_nxt;
				if (closing) begin
					// drop the column's sums; advance the index only when shown
					sum_q <= '0;
					abs_q <= '0;
					cnt_q <= '0;
					col_q <= emit ? base_col + 1'b1 : base_col;
				end else begin
					sum_q <= sum_nxt;
					abs_q <= abs_nxt;
					cnt_q <= cnt_nxt;
					col_q <= base_col;
				end
				if (emit) busy_q <= 1'b1;
			end
			if (load) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (spans.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job and output payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			col_job_q  <= base_col;
			hgt_job_q  <= h_cl;
			line_job_q <= line_mode;
			neg_job_q  <= sum_neg;
		end
		if (load) begin
			out_col_q <= col_job_q;
			out_top_q <= line_job_q ? line_top : dot_row;
			out_bot_q <= line_job_q ? line_bot[ROW_W-1:0] : dot_row;
		end
	end

	// Hold samples off while a column is in the unit.
	assign samples.ready    = !busy_q;
	assign spans.valid      = out_valid_q;
	assign spans.column     = out_col_q;
	assign spans.row_top    = out_top_q;
	assign spans.row_bottom = out_bot_q;

	`WCP_ASSERT(a_done_busy, clk, arst_n, res.done |-> busy_q, "unit result without a job")
	`WCP_ASSERT(a_rows_ordered, clk, arst_n, spans.valid |-> spans.row_top <= spans.row_bottom, "span upside down")
	`WCP_ASSERT(a_col_bound, clk, arst_n, col_q <= COL_W'(MAX_WIDTH), "column index past widest display")
	`WCP_ASSERT_RST(a_reset_quiet, clk, !arst_n |-> !spans.valid, "span shown in reset")

endmodule

FILE: tb/wcp_span_checker.sv
module wcp_span_checker import wcp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	wcp_in_if                    samples,
	wcp_out_if                   spans,
	output int                   fail_count,
	output int                   pending,
	output int                   span_count
);

	localparam int unsigned COUNT_CEIL = (1 << CNT_W) - 1;
	localparam int          PRINT_CAP  = 30;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row_top;
		logic [ROW_W-1:0] row_bottom;
	} span_t;

	// Shadow registers
	logic [CNT_W-1:0]  window_reg;
	logic [GAIN_W-1:0] gain_reg;
	logic [COL_W-1:0]  width_reg;
	logic [HGT_W-1:0]  height_reg;

	// Column accumulator state
	longint      col_sum;
	longint      col_abs;
	int unsigned col_n;
	int unsigned position;
	int unsigned col_idx;

	span_t predicted_spans[$];

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < PRINT_CAP)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic clear_column();
		col_sum = 0;
		col_abs = 0;
		col_n   = 0;
	endtask

	// Fold one sample into the column and predict the span it closes, if any.
	task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input logic ws);
		longint      sv;
		int unsigned w;
		int unsigned h;
		int unsigned z;
		longint      mid;
		longint      m1;
		longint      den;
		longint      a;
		longint      r;
		span_t       sp;
		sv = longint'(s);
		if (ws) begin
			clear_column();
			position = 0;
			col_idx  = 0;
		end
		w = clamp_dim(int'(width_reg), MIN_DIM, MAX_WIDTH);
		h = clamp_dim(int'(height_reg), MIN_DIM, MAX_HEIGHT);
		z = clamp_dim(int'(window_reg), MIN_DIM, MAX_WINDOW);
		col_sum += sv;
		col_abs += (sv < 0) ? -sv : sv;
		if (col_n < COUNT_CEIL)
			col_n++;
		if (position > z) begin
			if (col_idx < w) begin
				mid = longint'(h >> 1);
				m1  = mid - 1;
				den = longint'(col_n) << FRAC_SHIFT;
				if (z > LINE_MODE_LIMIT) begin
					a = col_abs * m1 * longint'(gain_reg) / den;
					if (a < 0)
						a = 0;
					if (a > m1)
						a = m1;
					sp.row_top    = ROW_W'(mid - a);
					sp.row_bottom = ROW_W'(mid + a);
				end else begin
					r = mid - col_sum * m1 * longint'(gain_reg) / den;
					if (r < 1)
						r = 1;
					if (r > longint'(h) - 1)
						r = longint'(h) - 1;
					sp.row_top    = ROW_W'(r);
					sp.row_bottom = ROW_W'(r);
				end
				sp.column = COL_W'(col_idx);
				predicted_spans.push_back(sp);
				col_idx++;
			end
			clear_column();
			position -= z;
		end
		position += w;
		if (position > COUNT_CEIL)
			position = COUNT_CEIL;
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_t want;
		if (!arst_n) begin
			window_reg = CNT_W'(WINDOW_RESET);
			gain_reg   = GAIN_W'(GAIN_RESET);
			width_reg  = COL_W'(WIDTH_RESET);
			height_reg = HGT_W'(HEIGHT_RESET);
			clear_column();
			position = 0;
			col_idx  = 0;
			predicted_spans.delete();
			pending    <= 0;
			fail_count = 0;
			span_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW: window_reg = cfg_data[CNT_W-1:0];
					REG_GAIN:   gain_reg   = cfg_data[GAIN_W-1:0];
					REG_WIDTH:  width_reg  = cfg_data[COL_W-1:0];
					REG_HEIGHT: height_reg = cfg_data[HGT_W-1:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				accumulate_sample(samples.sample, samples.window_start);
			if (spans.valid && spans.ready) begin
				span_count++;
				if (predicted_spans.size() == 0) begin
					report_mismatch("unpredicted span, column", int'(spans.column), -1);
				end else begin
					want = predicted_spans.pop_front();
					if (spans.column !== want.column)
						report_mismatch("column", int'(spans.column), int'(want.column));
					if (spans.row_top !== want.row_top)
						report_mismatch("row_top", int'(spans.row_top), int'(want.row_top));
					if (spans.row_bottom !== want.row_bottom)
						report_mismatch("row_bottom", int'(spans.row_bottom),
							int'(want.row_bottom));
				end
			end
			pending <= predicted_spans.size();
		end
	end

endmodule

FILE: tb/waveform_column_plotter_tb.sv
module waveform_column_plotter_tb import wcp_pkg::*; ();

	// Clock period is 8; settle() waits this long after a drain so that a column still in
	// the unit is done before the registers are touched.
	localparam int     SETTLE_CYCLES = 40;
	// Long receiver hold-off used to back the block up into its input.
	localparam int     HOLD_CYCLES   = 400;
	// Watchdog: far beyond the slowest legal run.
	localparam longint WATCHDOG      = 64'd8 * 64'd500000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// Flavor of the samples in one window
	typedef enum int {
		TONE_NOISE,
		TONE_EDGE,
		TONE_QUIET,
		TONE_LOUD
	} tone_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	wcp_in_if  in_bus();
	wcp_out_if out_bus();

	int fail_count;
	int pending;
	int span_count;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_go;
	int hold_left;
	int samples_sent;
	int settings_used;

	waveform_column_plotter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (in_bus),
		.spans     (out_bus)
	);

	wcp_span_checker span_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.samples    (in_bus),
		.spans      (out_bus),
		.fail_count (fail_count),
		.pending    (pending),
		.span_count (span_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog: a hung handshake or a lost span ends the run here.
	initial begin
		#(WATCHDOG);
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random stalls at the current rate, or a long hold-off on request.
	initial begin
		out_bus.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_left = HOLD_CYCLES;
				hold_go   = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 61;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 61;
			end
			default: begin
				send_idle_pct  = 33;
				recv_stall_pct = 33;
			end
		endcase
	endtask

	// Offer one sample, with random idle cycles ahead of it, and hold it until the
	// transaction completes. Valid stays high on return so back-to-back samples
	// need no extra assignment in the same step.
	task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic ws);
		while ($urandom_range(99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid        <= 1'b1;
		in_bus.sample       <= s;
		in_bus.window_start <= ws;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// Pause the sender until every predicted span has come out.
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Drain, then wait out any column the block may still be working on.
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; only the block's idle time is used.
	task automatic apply_config(input int unsigned win, input int unsigned gain,
			input int unsigned width, input int unsigned height);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WINDOW;
		cfg_data  <= CFG_W'(win);
		@(posedge clk);
		cfg_index <= REG_GAIN;
		cfg_data  <= CFG_W'(gain);
		@(posedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data  <= CFG_W'(width);
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= CFG_W'(height);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input tone_t tone);
		logic signed [SAMPLE_W-1:0] s;
		// Mix in plain noise so every bit pattern keeps turning up.
		if ($urandom_range(4) == 0)
			tone = TONE_NOISE;
		case (tone)
			TONE_EDGE: begin
				case ($urandom_range(4))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					2: s = 16'sh0000;
					3: s = 16'sh0001;
					default: s = 16'shFFFF;
				endcase
			end
			TONE_QUIET: s = $signed(SAMPLE_W'($urandom_range(0, 511))) - 16'sd256;
			TONE_LOUD: begin
				s = SAMPLE_W'($urandom_range(28000, 32767));
				if ($urandom_range(1))
					s = -s - 16'sd1;
			end
			default: s = SAMPLE_W'($urandom_range(0, 65535));
		endcase
		return s;
	endfunction

	// One register setting: settle, write it, then stream windows of random length.
	// Most windows open with a start flag; some run on without one and a rare stray
	// start breaks a window in the middle.
	task automatic run_setting(input int unsigned win, input int unsigned gain,
			input int unsigned width, input int unsigned height, input int n_items,
			input int len_lo, input int len_hi, input idle_mode_t mode, input bit press);
		int    left;
		int    wlen;
		int    k;
		tone_t tone;
		logic  ws;
		settle();
		apply_config(win, gain, width, height);
		set_idle(mode);
		left = n_items;
		while (left > 0) begin
			wlen = $urandom_range(len_lo, len_hi);
			tone = tone_t'($urandom_range(3));
			for (k = 0; k < wlen && left > 0; k++) begin
				if (k == 0)
					ws = ($urandom_range(9) != 0);
				else
					ws = ($urandom_range(99) == 0);
				// Back the block up: hold the receiver off while samples keep coming.
				if (press && left == n_items / 2)
					hold_go = 1'b1;
				// Let everything drain once mid-stream before carrying on.
				if (press && left == n_items / 4) begin
					in_bus.valid <= 1'b0;
					drain();
				end
				offer_sample(pick_sample(tone), ws);
				left--;
			end
		end
		in_bus.valid <= 1'b0;
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_WINDOW;
		cfg_data            <= '0;
		in_bus.valid        <= 1'b0;
		in_bus.sample       <= '0;
		in_bus.window_start <= 1'b0;
		hold_go       = 1'b0;
		samples_sent  = 0;
		settings_used = 0;
		set_idle(IDLE_NONE);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, samples with no window start ever given.
		offer_sample(16'sh7FFF, 1'b0);
		offer_sample(16'sh8000, 1'b0);
		offer_sample(16'sh0000, 1'b0);
		in_bus.valid <= 1'b0;

		// Dot mode, shortest window, widest and tallest display, top gain:
		// full-scale samples clamp at row 1 and at the last row.
		settle();
		apply_config(32, 1023, 1440, 512);
		offer_sample(16'sh7FFF, 1'b1);
		offer_sample(16'sh7FFF, 1'b0);
		offer_sample(16'sh8000, 1'b0);
		offer_sample(16'sh0000, 1'b0);
		offer_sample(16'sh0001, 1'b0);
		offer_sample(16'shFFFF, 1'b0);
		offer_sample(16'sh8000, 1'b1);
		offer_sample(16'sh7FFF, 1'b0);
		in_bus.valid <= 1'b0;

		// Line mode just above the limit, shortest display, gain 2.0.
		settle();
		apply_config(4097, 512, 1440, 32);
		offer_sample(16'sh8000, 1'b1);
		offer_sample(16'sh7FFF, 1'b0);
		offer_sample(16'sh7FFF, 1'b0);
		offer_sample(16'sh8000, 1'b0);
		offer_sample(16'sh0000, 1'b0);
		offer_sample(16'sh0001, 1'b0);
		offer_sample(16'sh8000, 1'b0);
		offer_sample(16'sh7FFF, 1'b0);
		offer_sample(16'shFFFF, 1'b0);
		in_bus.valid <= 1'b0;

		// Zero gain; window, width and height below their floors, so they clamp up.
		settle();
		apply_config(0, 0, 0, 0);
		offer_sample(16'sh7FFF, 1'b1);
		offer_sample(16'sh8000, 1'b0);
		offer_sample(16'sh7FFF, 1'b0);
		in_bus.valid <= 1'b0;

		// Random part: each setting under its own idle mode.
		run_setting(32, 256, 1440, 512, 300, 100, 400, IDLE_NONE, 1'b1);
		run_setting(0, 1023, 0, 0, 200, 10, 90, IDLE_SENDER, 1'b0);
		run_setting(4096, 512, 2047, 1023, 200, 50, 600, IDLE_RECEIVER, 1'b0);
		run_setting(4097, 256, 1440, 150, 250, 50, 600, IDLE_BOTH, 1'b0);
		run_setting(262143, 512, 1440, 512, 300, 300, 300, IDLE_NONE, 1'b0);
		run_setting(1000, 0, 100, 77, 200, 20, 300, IDLE_SENDER, 1'b0);
		run_setting(10000, 1023, 700, 33, 200, 50, 500, IDLE_RECEIVER, 1'b0);
		run_setting(64, 128, 32, 64, 150, 20, 150, IDLE_BOTH, 1'b0);

		settle();
		$display("Run covered %0d samples and %0d spans over %0d register settings,",
			samples_sent, span_count, settings_used);
		$display("dot and line mode, clamped registers and suppressed columns included.");
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
